FILE: rtl/core/rgbhsv_pkg.sv
package rgbhsv_pkg;

  localparam int CH_W  = 8;
  localparam int HUE_W = 15;
  localparam int SAT_W = 16;

  localparam logic [SAT_W-1:0] SAT_MAX = 16'hFFFF;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pix_in_t;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [SAT_W-1:0] saturation;
    logic [CH_W-1:0]  value;
  } pix_out_t;

  typedef enum logic [1:0] {
    SECT_RED,
    SECT_GREEN,
    SECT_BLUE
  } sector_t;

endpackage

FILE: rtl/core/rgb_to_hsv_converter_unit.sv
// RGB to HSV converter. One pixel is accepted per clock and one result leaves per
// clock while neither in_stall nor out_stall holds them back. The two bit-serial
// restoring dividers produce one quotient bit per pipeline stage for hue and
// saturation side by side, DIV_W bits each, where DIV_W is the larger of
// 17 + HUE_FRACTION_BITS and 8 + SAT_FRACTION_BITS (24 with the default parameters).
// A two-entry output buffer lets the pipeline keep running for one extra transfer
// after out_stall rises; in_stall is a registered flag of that buffer.
// Hue is in degrees with HUE_FRACTION_BITS fraction bits, saturation is delta over
// max with SAT_FRACTION_BITS fraction bits clipped to 16 bits, and value is the
// largest channel. A grey pixel gives zero hue and saturation.
module rgb_to_hsv_converter_unit #(
  parameter int HUE_FRACTION_BITS = 6,
  parameter int SAT_FRACTION_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  rgbhsv_pkg::pix_in_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output rgbhsv_pkg::pix_out_t out_data
);
  import rgbhsv_pkg::*;

  localparam int HUE_DIV_W = 17 + HUE_FRACTION_BITS;
  localparam int SAT_DIV_W = CH_W + SAT_FRACTION_BITS;
  localparam int DIV_W = (HUE_DIV_W > SAT_DIV_W) ? HUE_DIV_W : SAT_DIV_W;
  localparam int NUM_W = 11;
  localparam logic [DIV_W-1:0] HUE_SCALE = DIV_W'(60 * (1 << HUE_FRACTION_BITS));
  localparam logic [DIV_W-1:0] HUE_FULL = DIV_W'(360 * (1 << HUE_FRACTION_BITS));

  typedef struct packed {
    logic [DIV_W-1:0] hue_a;
    logic [CH_W-1:0]  hue_rem;
    logic [DIV_W-1:0] sat_a;
    logic [CH_W-1:0]  sat_rem;
    logic [CH_W-1:0]  delta;
    logic [CH_W-1:0]  mx;
    logic             neg;
  } div_stage_t;

  function automatic div_stage_t div_step(input div_stage_t s);
    div_stage_t      o;
    logic [CH_W:0]   th;
    logic [CH_W:0]   ts;
    o  = s;
    th = {s.hue_rem, s.hue_a[DIV_W-1]};
    ts = {s.sat_rem, s.sat_a[DIV_W-1]};
    if (th >= {1'b0, s.delta}) begin
      o.hue_rem = CH_W'(th - {1'b0, s.delta});
      o.hue_a   = {s.hue_a[DIV_W-2:0], 1'b1};
    end else begin
      o.hue_rem = th[CH_W-1:0];
      o.hue_a   = {s.hue_a[DIV_W-2:0], 1'b0};
    end
    if (ts >= {1'b0, s.mx}) begin
      o.sat_rem = CH_W'(ts - {1'b0, s.mx});
      o.sat_a   = {s.sat_a[DIV_W-2:0], 1'b1};
    end else begin
      o.sat_rem = ts[CH_W-1:0];
      o.sat_a   = {s.sat_a[DIV_W-2:0], 1'b0};
    end
    return o;
  endfunction

  logic en;

  logic            s1_valid_r;
  logic [CH_W-1:0] s1_red_r, s1_green_r, s1_blue_r, s1_mx_r, s1_mn_r;
  sector_t         s1_sect_r;
  logic [CH_W-1:0] s1_mx_nxt, s1_mn_nxt;
  sector_t         s1_sect_nxt;

  logic             s2_valid_r;
  logic [CH_W-1:0]  s2_mx_r, s2_delta_r;
  logic [NUM_W-1:0] s2_num_r;
  logic             s2_neg_r;
  logic [CH_W-1:0]  s2_delta_nxt;
  logic [NUM_W-1:0] s2_num_nxt;
  logic             s2_neg_nxt;

  logic       dv_valid_r [DIV_W+1];
  div_stage_t div_r [DIV_W+1];
  div_stage_t div0_nxt;

  div_stage_t fin;
  pix_out_t   res_nxt;
  logic       last_valid;

  logic     out_valid_r, skid_valid_r;
  pix_out_t out_data_r, skid_data_r;

  assign en       = !skid_valid_r;
  assign in_stall = skid_valid_r;

  always_comb begin
    s1_mx_nxt = in_data.red;
    if (in_data.green > s1_mx_nxt) s1_mx_nxt = in_data.green;
    if (in_data.blue > s1_mx_nxt) s1_mx_nxt = in_data.blue;
    s1_mn_nxt = in_data.red;
    if (in_data.green < s1_mn_nxt) s1_mn_nxt = in_data.green;
    if (in_data.blue < s1_mn_nxt) s1_mn_nxt = in_data.blue;
    if (in_data.red >= in_data.green && in_data.red >= in_data.blue) begin
      s1_sect_nxt = SECT_RED;
    end else if (in_data.green >= in_data.blue) begin
      s1_sect_nxt = SECT_GREEN;
    end else begin
      s1_sect_nxt = SECT_BLUE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_red_r   <= in_data.red;
      s1_green_r <= in_data.green;
      s1_blue_r  <= in_data.blue;
      s1_mx_r    <= s1_mx_nxt;
      s1_mn_r    <= s1_mn_nxt;
      s1_sect_r  <= s1_sect_nxt;
    end
  end

  always_comb begin
    s2_delta_nxt = s1_mx_r - s1_mn_r;
    s2_neg_nxt   = 1'b0;
    case (s1_sect_r)
      SECT_RED: begin
        if (s1_green_r >= s1_blue_r) begin
          s2_num_nxt = NUM_W'(s1_green_r - s1_blue_r);
        end else begin
          s2_num_nxt = NUM_W'(s1_blue_r - s1_green_r);
          s2_neg_nxt = 1'b1;
        end
      end
      SECT_GREEN: begin
        s2_num_nxt = NUM_W'(s1_blue_r) + (NUM_W'(s2_delta_nxt) << 1) - NUM_W'(s1_red_r);
      end
      SECT_BLUE: begin
        s2_num_nxt = NUM_W'(s1_red_r) + (NUM_W'(s2_delta_nxt) << 2) - NUM_W'(s1_green_r);
      end
      default: begin
        s2_num_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (en) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_mx_r    <= s1_mx_r;
      s2_delta_r <= s2_delta_nxt;
      s2_num_r   <= s2_num_nxt;
      s2_neg_r   <= s2_neg_nxt;
    end
  end

  always_comb begin
    div0_nxt.hue_a   = DIV_W'(s2_num_r) * HUE_SCALE;
    div0_nxt.hue_rem = '0;
    div0_nxt.sat_a   = DIV_W'(s2_delta_r) << SAT_FRACTION_BITS;
    div0_nxt.sat_rem = '0;
    div0_nxt.delta   = s2_delta_r;
    div0_nxt.mx      = s2_mx_r;
    div0_nxt.neg     = s2_neg_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_valid_r[0] <= 1'b0;
    end else if (en) begin
      dv_valid_r[0] <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div_r[0] <= div0_nxt;
    end
  end

  for (genvar i = 0; i < DIV_W; i++) begin : g_div
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_valid_r[i+1] <= 1'b0;
      end else if (en) begin
        dv_valid_r[i+1] <= dv_valid_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        div_r[i+1] <= div_step(div_r[i]);
      end
    end
  end

  assign fin        = div_r[DIV_W];
  assign last_valid = dv_valid_r[DIV_W] && en;

  always_comb begin
    res_nxt.value = fin.mx;
    if (fin.delta == '0) begin
      res_nxt.hue        = '0;
      res_nxt.saturation = '0;
    end else begin
      res_nxt.hue = fin.neg ? HUE_W'(HUE_FULL - fin.hue_a) : HUE_W'(fin.hue_a);
      if (|fin.sat_a[DIV_W-1:SAT_W]) begin
        res_nxt.saturation = SAT_MAX;
      end else begin
        res_nxt.saturation = fin.sat_a[SAT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || !out_stall) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= last_valid;
      end
    end else if (last_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || !out_stall) begin
      if (skid_valid_r) begin
        out_data_r <= skid_data_r;
      end else if (last_valid) begin
        out_data_r <= res_nxt;
      end
    end else if (last_valid) begin
      skid_data_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: rtl/core/rgbhsv_checker.sv
module rgbhsv_checker #(
  parameter int HUE_FRACTION_BITS = 6
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input rgbhsv_pkg::pix_out_t out_data
);
  import rgbhsv_pkg::*;

  localparam int HUE_LIMIT = 360 * (1 << HUE_FRACTION_BITS);

  // A result with zero saturation comes from a grey pixel, so its hue is zero too.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.saturation == '0 |-> out_data.hue == '0)
    else $error("nonzero hue with zero saturation");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.value == '0 |-> out_data.saturation == '0 && out_data.hue == '0)
    else $error("black pixel with nonzero hue or saturation");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && HUE_FRACTION_BITS <= 6 |-> out_data.hue < HUE_LIMIT)
    else $error("hue at or above a full turn");

  // The input side can only stall after a result was held on the output side.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(out_valid && out_stall))
    else $error("input stall without a held result");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

endmodule

bind rgb_to_hsv_converter_unit rgbhsv_checker #(
  .HUE_FRACTION_BITS(HUE_FRACTION_BITS)
) u_rgbhsv_checker (.*);

FILE: tb/hsv_checker.sv
`timescale 1ns / 100ps

module hsv_checker #(
  parameter int HUE_FRAC = 6,
  parameter int SAT_FRAC = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  rgbhsv_pkg::pix_in_t  in_data,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  rgbhsv_pkg::pix_out_t out_data,
  output int                   faults,
  output int                   pending,
  output int                   results_seen
);
  import rgbhsv_pkg::*;

  localparam longint unsigned HUE_SIXTH = 64'd60 << HUE_FRAC;
  localparam longint unsigned HUE_TURN  = 64'd360 << HUE_FRAC;

  pix_out_t hsv_due[$];

  function automatic pix_out_t hsv_of(input pix_in_t px);
    longint unsigned r, g, b, hi, lo, span, arc, sat;
    pix_out_t res;
    r = 64'(px.red);
    g = 64'(px.green);
    b = 64'(px.blue);
    hi = (r > g) ? r : g;
    hi = (hi > b) ? hi : b;
    lo = (r < g) ? r : g;
    lo = (lo < b) ? lo : b;
    span = hi - lo;
    arc = '0;
    sat = '0;
    if (span != 0) begin
      // Ties on the maximum resolve to red, then green, then blue.
      if (hi == r) begin
        if (g >= b) arc = (HUE_SIXTH * (g - b)) / span;
        else arc = HUE_TURN - (HUE_SIXTH * (b - g)) / span;
      end else if (hi == g) begin
        arc = (HUE_SIXTH * (b + 2 * span - r)) / span;
      end else begin
        arc = (HUE_SIXTH * (r + 4 * span - g)) / span;
      end
      sat = (span << SAT_FRAC) / hi;
      if (sat > SAT_MAX) sat = 64'(SAT_MAX);
    end
    res.hue        = arc[HUE_W-1:0];
    res.saturation = sat[SAT_W-1:0];
    res.value      = hi[CH_W-1:0];
    return res;
  endfunction

  always @(posedge clk) begin : watch
    pix_out_t want;
    if (!rst_n) begin
      faults = 0;
      pending      <= 0;
      results_seen <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen <= results_seen + 1;
        if (hsv_due.size() == 0) begin
          faults++;
          if (faults <= 10)
            $display("unexpected result: hue %0d sat %0d val %0d",
                     out_data.hue, out_data.saturation, out_data.value);
        end else begin
          want = hsv_due.pop_front();
          if (out_data.hue !== want.hue || out_data.saturation !== want.saturation ||
              out_data.value !== want.value) begin
            faults++;
            if (faults <= 10)
              $display("mismatch: expected hue %0d sat %0d val %0d, got hue %0d sat %0d val %0d",
                       want.hue, want.saturation, want.value,
                       out_data.hue, out_data.saturation, out_data.value);
          end
        end
      end
      if (in_valid && !in_stall) hsv_due.push_back(hsv_of(in_data));
      pending <= hsv_due.size();
    end
  end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps

module tb;
  import rgbhsv_pkg::*;

  localparam int HUE_FRAC       = 6;
  localparam int SAT_FRAC       = 16;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 40;
  localparam int WATCHDOG_LIMIT = 4000;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  pix_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  pix_out_t out_data;

  int faults;
  int pending;
  int results_seen;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit calm          = 1'b0;
  int hold_asks     = 0;
  int holds_done    = 0;
  int pixels_sent   = 0;
  int idle_cycles   = 0;

  rgb_to_hsv_converter_unit #(
    .HUE_FRACTION_BITS(HUE_FRAC),
    .SAT_FRACTION_BITS(SAT_FRAC)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  hsv_checker #(
    .HUE_FRAC(HUE_FRAC),
    .SAT_FRAC(SAT_FRAC)
  ) chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .faults      (faults),
    .pending     (pending),
    .results_seen(results_seen)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("tb: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // A requested hold keeps the output stalled long enough for the pipeline to back up.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_asks != holds_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        holds_done++;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  task automatic send_pixel(input pix_in_t px);
    while (!calm && ($urandom_range(99) < send_idle_pct)) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    do @(posedge clk); while (in_stall);
    pixels_sent++;
    @(negedge clk);
  endtask

  task automatic send_rgb(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    pix_in_t px;
    px.red   = r;
    px.green = g;
    px.blue  = b;
    send_pixel(px);
  endtask

  function automatic logic [7:0] rail_value();
    case ($urandom_range(3))
      0: return 8'd0;
      1: return 8'd1;
      2: return 8'd254;
      default: return 8'd255;
    endcase
  endfunction

  function automatic pix_in_t random_pixel();
    pix_in_t px;
    int base;
    px.red   = CH_W'($urandom_range(255));
    px.green = CH_W'($urandom_range(255));
    px.blue  = CH_W'($urandom_range(255));
    case ($urandom_range(9))
      5: begin
        base     = $urandom_range(253, 2);
        px.red   = CH_W'(base + $urandom_range(2) - 1);
        px.green = CH_W'(base + $urandom_range(2) - 1);
        px.blue  = CH_W'(base + $urandom_range(2) - 1);
      end
      6: begin
        case ($urandom_range(2))
          0: px.green = px.red;
          1: px.blue = px.red;
          default: px.blue = px.green;
        endcase
      end
      7: begin
        px.red   = rail_value();
        px.green = rail_value();
        px.blue  = rail_value();
      end
      8: begin
        px.green = px.red;
        px.blue  = px.red;
      end
      9: begin
        px.red   = CH_W'($urandom_range(3));
        px.green = CH_W'($urandom_range(3));
        px.blue  = CH_W'($urandom_range(3));
      end
      default: ;
    endcase
    return px;
  endfunction

  task automatic run_phase(input int send_pct, input int recv_pct, input int count,
                           input bit squeeze);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) calm = ($urandom_range(3) == 0);
      if (squeeze && n == 20) hold_asks++;
      send_pixel(random_pixel());
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_rgb(8'd0,   8'd0,   8'd0);
    send_rgb(8'd255, 8'd255, 8'd255);
    send_rgb(8'd128, 8'd128, 8'd128);
    send_rgb(8'd255, 8'd0,   8'd0);
    send_rgb(8'd0,   8'd255, 8'd0);
    send_rgb(8'd0,   8'd0,   8'd255);
    send_rgb(8'd255, 8'd255, 8'd0);
    send_rgb(8'd0,   8'd255, 8'd255);
    send_rgb(8'd255, 8'd0,   8'd255);
    send_rgb(8'd255, 8'd1,   8'd0);
    send_rgb(8'd255, 8'd0,   8'd1);
    send_rgb(8'd1,   8'd255, 8'd0);
    send_rgb(8'd0,   8'd255, 8'd1);
    send_rgb(8'd1,   8'd0,   8'd255);
    send_rgb(8'd0,   8'd1,   8'd255);
    send_rgb(8'd1,   8'd0,   8'd0);
    send_rgb(8'd0,   8'd0,   8'd1);
    send_rgb(8'd2,   8'd1,   8'd1);
    send_rgb(8'd255, 8'd254, 8'd254);
    send_rgb(8'd254, 8'd255, 8'd255);
    send_rgb(8'd170, 8'd85,  8'd0);

    run_phase(30, 62, 380, 1'b0);
    in_valid <= 1'b0;
    wait (pending == 0);
    @(negedge clk);
    run_phase(62, 30, 380, 1'b0);
    run_phase(0, 0, 340, 1'b1);
    in_valid <= 1'b0;

    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d pixels (grey, primaries, ties, near-grey, rails, random)",
             pixels_sent);
    $display("and %0d checked results under mixed stalls, a long output hold and a drain.",
             results_seen);
    if (faults == 0 && pending == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/rgbhsv_pkg.sv
rtl/core/rgb_to_hsv_converter_unit.sv
rtl/core/rgbhsv_checker.sv
tb/hsv_checker.sv
tb/tb.sv
